// File: hdl/ppm_pkg.sv
// Package for the PPM pulse decoder: field widths, channel count and result kinds.
// Used by the channel interfaces and by ppm_pulse_decoder; depends on nothing.
`default_nettype none

package ppm_pkg;

    localparam int MAX_CHANNELS = 8;

    localparam int TICK_W  = 22;
    localparam int COUNT_W = 16;
    localparam int WRAP_W  = 6;
    localparam int SLOT_W  = 3;
    localparam int CHAN_W  = $clog2(MAX_CHANNELS + 1);

    localparam logic [TICK_W-1:0] SYNC_THRESHOLD_RESET = TICK_W'(3000);
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS        = '1;
    localparam logic [WRAP_W-1:0] WRAP_LIMIT           = '1;
    localparam logic [CHAN_W-1:0] CHAN_FULL            = CHAN_W'(MAX_CHANNELS);

    typedef enum logic [1:0] {
        KIND_STORED  = 2'd0,
        KIND_SYNC    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_DROPPED = 2'd3
    } pulse_kind_t;

endpackage

`default_nettype wire

// File: hdl/ppm_in_if.sv
// Input channel of the PPM pulse decoder: timer events with valid/ready handshake.
// Depends on ppm_pkg for the field widths.
`default_nettype none

interface ppm_in_if
    import ppm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               overflow_event;
    logic               capture_event;
    logic [COUNT_W-1:0] captured_count;

    modport source (output valid, output overflow_event, output capture_event,
                    output captured_count, input ready);
    modport sink   (input valid, input overflow_event, input capture_event,
                    input captured_count, output ready);
endinterface

`default_nettype wire

// File: hdl/ppm_out_if.sv
// Result channel of the PPM pulse decoder: measured pulses with valid/ready handshake.
// Depends on ppm_pkg for the field widths and the result kind type.
`default_nettype none

interface ppm_out_if
    import ppm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] pulse_ticks;
    logic [SLOT_W-1:0] channel_slot;
    pulse_kind_t       pulse_kind;

    modport source (output valid, output pulse_ticks, output channel_slot,
                    output pulse_kind, input ready);
    modport sink   (input valid, input pulse_ticks, input channel_slot,
                    input pulse_kind, output ready);
endinterface

`default_nettype wire

// File: hdl/ppm_pulse_decoder.sv
// PPM pulse decoder top level: input register, pulse measurement logic, result register.
// Depends on ppm_pkg, ppm_in_if and ppm_out_if.
`default_nettype none

// The decoder takes one timer-event transaction per clock cycle while input ready is high
// and returns at most one result transaction for it. Each transaction passes an input
// register and then a single stage of compare and count logic that updates the pulse state
// and loads the result register, so the sustained rate is one transaction per cycle while
// the result channel is not stalled. The result register lets a new transaction enter while
// a finished result still waits; input ready drops only when a result is pending, the
// result register is full and the result channel is stalled. The sync threshold must be
// written only while the decoder is idle.
module ppm_pulse_decoder
    import ppm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [TICK_W-1:0] cfg_wr_data,
    ppm_in_if.sink                 pulse_in,
    ppm_out_if.source              pulse_out
);

    logic [TICK_W-1:0]  sync_threshold_reg;

    logic               in_valid_reg;
    logic               in_ovf_reg;
    logic               in_cap_reg;
    logic [COUNT_W-1:0] in_count_reg;

    logic               measuring_reg, measuring_next;
    logic [WRAP_W-1:0]  wrap_reg, wrap_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;

    logic               out_valid_reg;
    logic [TICK_W-1:0]  out_ticks_reg, out_ticks_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    pulse_kind_t        out_kind_reg, out_kind_next;

    logic               timeout;
    logic               produces;
    logic               advance;
    logic               load_out;
    logic [WRAP_W-1:0]  wrap_inc;
    logic [TICK_W-1:0]  width;

    assign timeout  = in_ovf_reg && measuring_reg && (wrap_reg == WRAP_LIMIT);
    assign produces = timeout || (in_cap_reg && measuring_reg);
    assign advance  = in_valid_reg && (!produces || !out_valid_reg || pulse_out.ready);
    assign load_out = advance && produces;
    assign wrap_inc = (in_ovf_reg && measuring_reg) ? wrap_reg + WRAP_W'(1) : wrap_reg;
    assign width    = {wrap_inc, in_count_reg};

    assign pulse_in.ready = !in_valid_reg || advance;

    always_comb
    begin
        measuring_next = measuring_reg;
        wrap_next      = wrap_reg;
        chan_next      = chan_reg;
        out_ticks_next = width;
        out_slot_next  = '0;
        out_kind_next  = KIND_STORED;
        if (timeout)
        begin
            measuring_next = 1'b0;
            wrap_next      = '0;
            out_ticks_next = TIMEOUT_TICKS;
            out_kind_next  = KIND_TIMEOUT;
        end
        else if (in_cap_reg && !measuring_reg)
        begin
            measuring_next = 1'b1;
            wrap_next      = '0;
        end
        else if (in_cap_reg)
        begin
            measuring_next = 1'b0;
            wrap_next      = '0;
            if (width > sync_threshold_reg)
            begin
                chan_next     = '0;
                out_kind_next = KIND_SYNC;
            end
            else if (chan_reg < CHAN_FULL)
            begin
                chan_next     = chan_reg + CHAN_W'(1);
                out_slot_next = SLOT_W'(chan_reg);
                out_kind_next = KIND_STORED;
            end
            else
            begin
                out_kind_next = KIND_DROPPED;
            end
        end
        else
        begin
            wrap_next = wrap_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_threshold_reg <= SYNC_THRESHOLD_RESET;
            in_valid_reg       <= 1'b0;
            measuring_reg      <= 1'b0;
            wrap_reg           <= '0;
            chan_reg           <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                sync_threshold_reg <= cfg_wr_data;
            end
            if (pulse_in.ready)
            begin
                in_valid_reg <= pulse_in.valid;
            end
            if (advance)
            begin
                measuring_reg <= measuring_next;
                wrap_reg      <= wrap_next;
                chan_reg      <= chan_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pulse_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pulse_in.ready && pulse_in.valid)
        begin
            in_ovf_reg   <= pulse_in.overflow_event;
            in_cap_reg   <= pulse_in.capture_event;
            in_count_reg <= pulse_in.captured_count;
        end
        if (load_out)
        begin
            out_ticks_reg <= out_ticks_next;
            out_slot_reg  <= out_slot_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    assign pulse_out.valid        = out_valid_reg;
    assign pulse_out.pulse_ticks  = out_ticks_reg;
    assign pulse_out.channel_slot = out_slot_reg;
    assign pulse_out.pulse_kind   = out_kind_reg;

    a_idle_wrap_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !measuring_reg |-> wrap_reg == '0)
        else $error("Overflow count is not zero while no pulse is open.");

    a_chan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg <= CHAN_FULL)
        else $error("Channel index ran past the channel count.");

    a_timeout_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_TIMEOUT |->
            out_ticks_reg == TIMEOUT_TICKS && out_slot_reg == '0)
        else $error("Timeout result carries wrong fields.");

    a_sync_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && out_kind_next == KIND_SYNC |=> chan_reg == '0 && !measuring_reg)
        else $error("Sync gap did not restart the channel index.");

endmodule

`default_nettype wire

// File: tb/ppm_pulse_decoder_tb.sv
// Self-checking testbench for ppm_pulse_decoder: timer events in, decoded pulse widths out.
// Depends on ppm_pkg, ppm_in_if, ppm_out_if and ppm_pulse_decoder from the hdl folder.
// A built-in pulse decoder model predicts each result; several sync thresholds are exercised.
module ppm_pulse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppm_pkg::*;

    localparam int unsigned TICK_MAX = (1 << TICK_W) - 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               ovf;
        logic               cap;
        logic [COUNT_W-1:0] count;
    } timer_event_t;

    typedef struct packed {
        logic [TICK_W-1:0] ticks;
        logic [SLOT_W-1:0] slot;
        pulse_kind_t       kind;
    } pulse_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TICK_W-1:0] cfg_wr_data;

    ppm_in_if  in_ch();
    ppm_out_if out_ch();

    ppm_pulse_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pulse_in   (in_ch),
        .pulse_out  (out_ch)
    );

    timer_event_t  pending_events[$];
    pulse_result_t expected_pulses[$];

    // Decoder model state.
    logic              pulse_open    = 1'b0;
    logic [WRAP_W-1:0] wraps_seen    = '0;
    int unsigned       slot_next     = 0;
    logic [TICK_W-1:0] sync_level    = SYNC_THRESHOLD_RESET;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    logic        in_taken      = 1'b0;
    int          cycles        = 0;
    int          mismatches    = 0;
    int          events_taken  = 0;
    int          pulses_checked = 0;
    int          kinds_seen[4] = '{0, 0, 0, 0};
    int          planned       = 0;
    timer_event_t  next_event;
    pulse_result_t got_pulse;
    pulse_result_t want_pulse;
    pulse_result_t new_pulse;

    function automatic bit decode_event(input timer_event_t ev, output pulse_result_t res);
        logic [TICK_W-1:0] width;
        res = '0;
        if (ev.ovf && pulse_open) begin
            if (wraps_seen == WRAP_LIMIT) begin
                pulse_open = 1'b0;
                wraps_seen = '0;
                res.ticks  = TIMEOUT_TICKS;
                res.kind   = KIND_TIMEOUT;
                return 1'b1;
            end
            wraps_seen = wraps_seen + WRAP_W'(1);
        end
        if (!ev.cap) begin
            return 1'b0;
        end
        if (!pulse_open) begin
            pulse_open = 1'b1;
            wraps_seen = '0;
            return 1'b0;
        end
        width      = {wraps_seen, ev.count};
        pulse_open = 1'b0;
        wraps_seen = '0;
        res.ticks  = width;
        if (width > sync_level) begin
            slot_next = 0;
            res.kind  = KIND_SYNC;
        end
        else if (slot_next < MAX_CHANNELS) begin
            res.slot  = SLOT_W'(slot_next);
            res.kind  = KIND_STORED;
            slot_next = slot_next + 1;
        end
        else begin
            res.kind = KIND_DROPPED;
        end
        return 1'b1;
    endfunction

    task automatic report_pulse(input string what, input pulse_result_t want,
                                input pulse_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s: expected ticks %0d slot %0d kind %0d,",
                     $time, what, want.ticks, want.slot, want.kind);
            $display("    got ticks %0d slot %0d kind %0d", got.ticks, got.slot, got.kind);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Input driver.
    always @(negedge clk) begin
        if (!in_ch.valid || in_taken) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_event = pending_events.pop_front();
                in_ch.valid          <= 1'b1;
                in_ch.overflow_event <= next_event.ovf;
                in_ch.capture_event  <= next_event.cap;
                in_ch.captured_count <= next_event.count;
            end
            else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with a long hold-off whenever one is requested.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_requests) begin
            hold_served  <= hold_served + 1;
            hold_left    <= 300;
            out_ch.ready <= 1'b0;
        end
        else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor and checker.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycles, expected_pulses.size());
            $display("ppm_pulse_decoder regression: fail");
            $finish;
        end
        in_taken <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n) begin
            if (cfg_wr_en) begin
                sync_level = cfg_wr_data;
            end
            if (out_ch.valid && out_ch.ready) begin
                got_pulse.ticks = out_ch.pulse_ticks;
                got_pulse.slot  = out_ch.channel_slot;
                got_pulse.kind  = out_ch.pulse_kind;
                if (expected_pulses.size() == 0) begin
                    report_pulse("result with none expected", '0, got_pulse);
                end
                else begin
                    want_pulse = expected_pulses.pop_front();
                    pulses_checked++;
                    if (got_pulse.ticks !== want_pulse.ticks
                        || got_pulse.slot !== want_pulse.slot
                        || got_pulse.kind !== want_pulse.kind) begin
                        report_pulse("result mismatch", want_pulse, got_pulse);
                    end
                    else begin
                        kinds_seen[want_pulse.kind]++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                events_taken++;
                if (decode_event({in_ch.overflow_event, in_ch.capture_event,
                                  in_ch.captured_count}, new_pulse)) begin
                    expected_pulses.push_back(new_pulse);
                end
            end
        end
    end

    task automatic add_event(input bit ovf, input bit cap, input logic [COUNT_W-1:0] count);
        timer_event_t ev;
        ev.ovf   = ovf;
        ev.cap   = cap;
        ev.count = count;
        pending_events.push_back(ev);
        planned++;
    endtask

    task automatic add_pulse(input int unsigned width);
        int unsigned        wraps;
        logic [COUNT_W-1:0] tail;
        bit                 merged;
        wraps  = width >> COUNT_W;
        tail   = width[COUNT_W-1:0];
        merged = 1'b0;
        add_event(1'($urandom_range(0, 1)), 1'b1, COUNT_W'($urandom));
        for (int i = 0; i < wraps; i++) begin
            if (i == wraps - 1 && $urandom_range(0, 1)) begin
                add_event(1'b1, 1'b1, tail);
                merged = 1'b1;
            end
            else begin
                add_event(1'b1, 1'b0, COUNT_W'($urandom));
            end
        end
        if (!merged) begin
            add_event(1'b0, 1'b1, tail);
        end
    endtask

    function automatic int unsigned pick_width(input int unsigned level);
        int unsigned pick;
        int unsigned top;
        pick = $urandom_range(0, 99);
        top  = (level > 200000) ? 200000 : level;
        if (pick < 5) return level;
        if (pick < 10) return (level == TICK_MAX) ? level : level + 1;
        if (pick < 15) return (level == 0) ? 0 : level - 1;
        if (pick < 55) return $urandom_range(0, top);
        if (pick < 85) return $urandom_range(0, 65535);
        if (pick < 93) begin
            return (level >= TICK_MAX - 100000) ? TICK_MAX : level + $urandom_range(1, 100000);
        end
        return $urandom_range(63 * 65536, TICK_MAX);
    endfunction

    task automatic add_frame(input int unsigned level);
        int unsigned top;
        top = (level > 200000) ? 200000 : level;
        if (level < TICK_MAX) begin
            add_pulse((level >= TICK_MAX - 1000) ? TICK_MAX : level + 1 + $urandom_range(0, 1000));
        end
        repeat ($urandom_range(0, 10)) begin
            add_pulse($urandom_range(0, top));
        end
    endtask

    task automatic add_timeout();
        add_event(1'($urandom_range(0, 1)), 1'b1, COUNT_W'($urandom));
        repeat (63) begin
            add_event(1'b1, 1'b0, COUNT_W'($urandom));
        end
        add_event(1'b1, 1'($urandom_range(0, 1)), COUNT_W'($urandom));
    endtask

    task automatic settle(input int extra);
        do begin
            @(negedge clk);
        end while (pending_events.size() != 0 || in_ch.valid || expected_pulses.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic run_phase(input bit write_level, input int unsigned level, input int send_pct,
                             input int stall_pct, input bit hold, input int goal);
        int pick;
        settle(8);
        if (write_level) begin
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= TICK_W'(level);
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
        end
        @(posedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (hold) begin
            hold_requests++;
        end
        planned = 0;
        while (planned < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                add_pulse(pick_width(level));
            end
            else if (pick < 75) begin
                add_frame(level);
            end
            else if (pick < 78) begin
                add_timeout();
            end
            else begin
                repeat ($urandom_range(1, 3)) begin
                    add_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              COUNT_W'($urandom));
                end
            end
        end
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = '0;
        in_ch.valid          = 1'b0;
        in_ch.overflow_event = 1'b0;
        in_ch.capture_event  = 1'b0;
        in_ch.captured_count = '0;
        out_ch.ready         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed opening at the reset threshold of 3000.
        add_event(1'b1, 1'b0, 16'hFFFF);
        add_event(1'b0, 1'b0, 16'h0000);
        add_event(1'b1, 1'b1, 16'hFFFF);
        add_event(1'b0, 1'b1, 16'h0000);
        add_event(1'b0, 1'b1, 16'h1234);
        add_event(1'b0, 1'b1, 16'd3000);
        add_event(1'b0, 1'b1, 16'h0000);
        add_event(1'b0, 1'b1, 16'd3001);
        add_event(1'b0, 1'b1, 16'h0000);
        add_event(1'b1, 1'b1, 16'h0000);
        repeat (9) begin
            add_event(1'b0, 1'b1, COUNT_W'($urandom));
            add_event(1'b0, 1'b1, 16'd1000);
        end

        run_phase(1'b0, 3000, 0, 0, 1'b0, 330);
        run_phase(1'b1, 0, 50, 0, 1'b0, 360);
        run_phase(1'b1, TICK_MAX, 0, 50, 1'b0, 360);
        run_phase(1'b1, $urandom_range(1000, 300000), 25, 25, 1'b0, 360);
        run_phase(1'b1, 3000, 0, 0, 1'b1, 360);
        settle(20);

        $display("Checked %0d results from %0d timer event transactions over five phases.",
                 pulses_checked, events_taken);
        $display("Results by kind: %0d stored, %0d sync, %0d timeout, %0d dropped; %0d mismatches.",
                 kinds_seen[KIND_STORED], kinds_seen[KIND_SYNC], kinds_seen[KIND_TIMEOUT],
                 kinds_seen[KIND_DROPPED], mismatches);
        if (mismatches == 0) begin
            $display("ppm_pulse_decoder regression: pass");
        end
        else begin
            $display("ppm_pulse_decoder regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/ppm_pkg.sv
hdl/ppm_in_if.sv
hdl/ppm_out_if.sv
hdl/ppm_pulse_decoder.sv
tb/ppm_pulse_decoder_tb.sv
